[hw/rtl/bounded_priority_list_queue_top_macros.svh]
// Assertion macros used by the checker of the priority list queue.
`ifndef BOUNDED_PRIORITY_LIST_QUEUE_TOP_MACROS_SVH
`define BOUNDED_PRIORITY_LIST_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, quiet during reset.
`define BPLQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bplq assertion failed");

// Next-cycle implication, sampled on aclk, quiet during reset.
`define BPLQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bplq assertion failed");

`endif

[hw/rtl/bplq_pkg.sv]
// Types and constants of the bounded priority list queue.
package bplq_pkg;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int ENTRY_CNT_W = 5;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_REM_HEAD = 2'd2,
        CMD_REM_MAX  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_REM  = 2'd2
    } op_t;

    // Broadcast update: insert at pos (shift tail-ward) or remove at pos (shift head-ward)
    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] pos;
    } apply_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     have;
        logic                     found;
        logic [CNT_W-1:0]         pos;
        logic signed [DATA_W-1:0] best;
    } wave_t;

endpackage

[hw/rtl/bplq_cell.sv]
// One list position: holds an entry, joins the search wave and the shift.
module bplq_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bplq_pkg::CNT_W-1:0]        idx,
    input  logic [bplq_pkg::CNT_W-1:0]        count,
    input  bplq_pkg::cmd_t                    cmd,
    input  logic signed [bplq_pkg::DATA_W-1:0] value,
    input  bplq_pkg::apply_t                  apply,
    input  logic signed [bplq_pkg::DATA_W-1:0] prev_entry,
    input  logic signed [bplq_pkg::DATA_W-1:0] next_entry,
    input  bplq_pkg::wave_t                   wave_in,
    output logic signed [bplq_pkg::DATA_W-1:0] entry,
    output bplq_pkg::wave_t                   wave_out
);
    import bplq_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    wave_t                    wave_reg;
    wave_t                    wave_next;
    logic                     occupied;

    assign occupied = (idx < count);

    always_comb begin
        wave_next = wave_in;
        if (wave_in.valid && occupied) begin
            if (cmd == CMD_INSERT) begin
                // first entry not above the new value
                if (!wave_in.found && (entry_reg <= value)) begin
                    wave_next.found = 1'b1;
                    wave_next.pos   = idx;
                end
            end else begin
                // strict compare keeps the first occurrence of the maximum
                if (!wave_in.have || (entry_reg > wave_in.best)) begin
                    wave_next.have = 1'b1;
                    wave_next.best = entry_reg;
                    wave_next.pos  = idx;
                end
            end
        end
    end

    always_comb begin
        entry_next = entry_reg;
        unique case (apply.op)
            OP_INS: begin
                priority if (idx > apply.pos) entry_next = prev_entry;
                else if (idx == apply.pos) entry_next = value;
                else entry_next = entry_reg;
            end
            OP_REM: begin
                if (idx >= apply.pos) entry_next = next_entry;
            end
            OP_NONE: entry_next = entry_reg;
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg.valid <= 1'b0;
        end else begin
            wave_reg.valid <= wave_next.valid;
        end
        wave_reg.have  <= wave_next.have;
        wave_reg.found <= wave_next.found;
        wave_reg.pos   <= wave_next.pos;
        wave_reg.best  <= wave_next.best;
    end

    assign entry    = entry_reg;
    assign wave_out = wave_reg;

endmodule

[hw/rtl/bounded_priority_list_queue_top.sv]
// Sorted-list priority queue of up to DEPTH signed 32-bit values, one request at a time.
// Append and remove-head go straight to the finish state; insert-sorted and remove-maximum
// first pass the scan state, where the search wave walks the row of cells one position per
// cycle. The finish state writes the output register once it is free. The next request is
// taken once the previous result sits there, even while that result is still waiting.
module bounded_priority_list_queue_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bplq_pkg::CMD_W-1:0]         s_command,
    input  logic signed [bplq_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic signed [bplq_pkg::DATA_W-1:0] m_removed_value,
    output logic [bplq_pkg::ENTRY_CNT_W-1:0]   m_entry_count,
    output logic                               m_is_empty
);
    import bplq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     start_reg, start_next;
    logic [CNT_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] best_reg;

    logic                     m_valid_reg;
    logic                     m_ok_reg;
    logic signed [DATA_W-1:0] m_removed_value_reg;
    logic [ENTRY_CNT_W-1:0]   m_entry_count_reg;
    logic                     m_is_empty_reg;

    logic signed [DATA_W-1:0] entry_q [DEPTH];
    wave_t                    wave_q  [DEPTH];
    wave_t                    wave_start;
    apply_t                   apply;

    logic                     accept;
    logic                     out_free;
    logic                     fire;
    logic                     ok;
    op_t                      op;
    logic [CNT_W-1:0]         op_pos;
    logic signed [DATA_W-1:0] removed;
    logic [CNT_W+ENTRY_CNT_W-1:0] count_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == ST_FINISH) && out_free;

    always_comb begin
        wave_start       = '0;
        wave_start.valid = start_reg;
        wave_start.pos   = count_reg;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] prev_e;
        logic signed [DATA_W-1:0] next_e;
        wave_t                    w_in;

        if (i == 0) begin : g_head
            assign prev_e = value_reg;
            assign w_in   = wave_start;
        end else begin : g_body
            assign prev_e = entry_q[i-1];
            assign w_in   = wave_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_inner
            assign next_e = entry_q[i+1];
        end

        bplq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .idx        (CNT_W'(i)),
            .count      (count_reg),
            .cmd        (cmd_reg),
            .value      (value_reg),
            .apply      (apply),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .wave_in    (w_in),
            .entry      (entry_q[i]),
            .wave_out   (wave_q[i])
        );
    end

    // settle the request once the output register is free
    always_comb begin
        ok      = 1'b0;
        op      = OP_NONE;
        op_pos  = '0;
        removed = '0;
        unique case (cmd_reg)
            CMD_INSERT: begin
                ok     = (count_reg < FULL_COUNT);
                op     = OP_INS;
                op_pos = pos_reg;
            end
            CMD_APPEND: begin
                ok     = (count_reg < FULL_COUNT);
                op     = OP_INS;
                op_pos = count_reg;
            end
            CMD_REM_HEAD: begin
                ok      = (count_reg != '0);
                op      = OP_REM;
                op_pos  = '0;
                removed = entry_q[0];
            end
            CMD_REM_MAX: begin
                ok      = (count_reg != '0);
                op      = OP_REM;
                op_pos  = pos_reg;
                removed = best_reg;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok) begin
            removed = '0;
        end

        apply.op  = (fire && ok) ? op : OP_NONE;
        apply.pos = op_pos;

        count_next = count_reg;
        if (fire && ok) begin
            if (op == OP_INS) count_next = count_reg + 1'b1;
            else              count_next = count_reg - 1'b1;
        end
        count_ext = {{ENTRY_CNT_W{1'b0}}, count_next};
    end

    always_comb begin
        state_next = state_reg;
        start_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (cmd_t'(s_command) == CMD_INSERT || cmd_t'(s_command) == CMD_REM_MAX) begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (wave_q[DEPTH-1].valid) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= cmd_t'(s_command);
            value_reg <= s_value;
        end
        if (state_reg == ST_SCAN && wave_q[DEPTH-1].valid) begin
            pos_reg  <= wave_q[DEPTH-1].pos;
            best_reg <= wave_q[DEPTH-1].best;
        end
        if (fire) begin
            m_ok_reg            <= ok;
            m_removed_value_reg <= removed;
            m_entry_count_reg   <= count_ext[ENTRY_CNT_W-1:0];
            m_is_empty_reg      <= (count_next == '0);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_removed_value = m_removed_value_reg;
    assign m_entry_count   = m_entry_count_reg;
    assign m_is_empty      = m_is_empty_reg;

endmodule

[hw/rtl/bplq_checker.sv]
// Port-level checks of the priority list queue, bound to the top level.
`include "bounded_priority_list_queue_top_macros.svh"

module bplq_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [bplq_pkg::CMD_W-1:0]         s_command,
    input logic signed [bplq_pkg::DATA_W-1:0] s_value,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_ok,
    input logic signed [bplq_pkg::DATA_W-1:0] m_removed_value,
    input logic [bplq_pkg::ENTRY_CNT_W-1:0]   m_entry_count,
    input logic                               m_is_empty
);
    import bplq_pkg::*;

    // a waiting result holds still: valid, ok flag and removed value
    `BPLQ_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable({m_ok, m_removed_value}))
    // a waiting request holds still
    `BPLQ_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable({s_command, s_value}))
    // empty flag agrees with the reported count
    `BPLQ_ASSERT_NOW(a_empty_count, m_valid, m_is_empty == (m_entry_count == '0))
    // a refused request never reports a removed value
    `BPLQ_ASSERT_NOW(a_fail_zero, m_valid && !m_ok, m_removed_value == '0)
    // one request in flight: taking one closes the input side
    `BPLQ_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

bind bounded_priority_list_queue_top bplq_checker u_bplq_checker (.*);
